FILE: design/pi_regulator_clamped_delayed_core_defines.svh
// assertion macros shared by the pi regulator rtl
// no dependencies; included by modules that carry concurrent checks
`ifndef PI_REGULATOR_CLAMPED_DELAYED_CORE_DEFINES_SVH
`define PI_REGULATOR_CLAMPED_DELAYED_CORE_DEFINES_SVH

// same-cycle implication
`define PIRC_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define PIRC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: design/pirc_pkg.sv
// shared types and constants for the pi regulator core
// no dependencies; imported by pirc_calc and the top level
package pirc_pkg;

   localparam int REF_W      = 16;
   localparam int DRIVE_W    = 32;
   localparam int PGAIN_W    = 16;
   localparam int IGAIN_W    = 24;
   localparam int ILIMIT_W   = 31;
   localparam int DELAY_W    = 4;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W = 32;

   localparam int MAX_DELAY_DEFAULT = 8;

   localparam logic [PGAIN_W-1:0]  PGAIN_RESET  = 16'd128;
   localparam logic [IGAIN_W-1:0]  IGAIN_RESET  = 24'd10486;
   localparam logic [ILIMIT_W-1:0] ILIMIT_RESET = 31'd65536;
   localparam logic [DELAY_W-1:0]  DELAY_RESET  = 4'd3;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_PGAIN  = 2'd0,
      CSR_IGAIN  = 2'd1,
      CSR_ILIMIT = 2'd2,
      CSR_DELAY  = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [PGAIN_W-1:0]  pgain;
      logic [IGAIN_W-1:0]  igain;
      logic [ILIMIT_W-1:0] ilimit;
   } gains_type;

endpackage

FILE: design/pirc_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
module pirc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 8,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: design/pirc_calc.sv
// pi datapath: error, rounded gain products, clamped integral, saturated output
// depends on pirc_pkg
module pirc_calc (
   input  logic signed [pirc_pkg::REF_W-1:0]   reference,
   input  logic signed [pirc_pkg::REF_W-1:0]   feedback,
   input  pirc_pkg::gains_type                 gains,
   input  logic signed [pirc_pkg::DRIVE_W-1:0] integ_cur,
   output logic signed [pirc_pkg::DRIVE_W-1:0] integ_next,
   output logic signed [pirc_pkg::DRIVE_W-1:0] drive_now
);
   import pirc_pkg::*;

   logic signed [16:0] err;
   logic signed [41:0] iprod;
   logic signed [41:0] iprod_rnd;
   logic signed [33:0] acc;
   logic signed [33:0] acc_c;
   logic signed [33:0] lim_pos;
   logic signed [33:0] lim_neg;
   logic signed [33:0] pprod;
   logic signed [33:0] pprod_rnd;
   logic signed [33:0] outv;

   assign err       = $signed({reference[15], reference}) - $signed({feedback[15], feedback});
   assign iprod     = $signed({1'b0, gains.igain}) * err;
   assign iprod_rnd = iprod + 42'sd8192;
   assign acc       = $signed({{2{integ_cur[31]}}, integ_cur})
                    + $signed({{6{iprod_rnd[41]}}, iprod_rnd[41:14]});
   assign lim_pos   = $signed({3'b000, gains.ilimit});
   assign lim_neg   = -lim_pos;

   always_comb begin
      if (acc > lim_pos) begin
         acc_c = lim_pos;
      end else if (acc < lim_neg) begin
         acc_c = lim_neg;
      end else begin
         acc_c = acc;
      end
   end

   assign integ_next = acc_c[31:0];

   assign pprod     = $signed({1'b0, gains.pgain}) * err;
   assign pprod_rnd = pprod + 34'sd2;
   assign outv      = acc_c + $signed({{2{pprod_rnd[33]}}, pprod_rnd[33:2]});

   always_comb begin
      if (!outv[33] && (outv[32] || outv[31])) begin
         drive_now = {1'b0, {(DRIVE_W-1){1'b1}}};
      end else if (outv[33] && !(outv[32] && outv[31])) begin
         drive_now = {1'b1, {(DRIVE_W-1){1'b0}}};
      end else begin
         drive_now = outv[31:0];
      end
   end

endmodule

FILE: design/pi_regulator_clamped_delayed_core.sv
// pi regulator with clamped integral and an output delay line
// an accepted req passes the input register, then the result register, before rsp_valid
// throughput: one item per cycle while rsp_ready is not held low; set by the integrator update loop
// delay line lives in pirc_ram; one read at accept, one write per finished item
// reset clears control, integrator, write pointer and history valid bits; no sweep
// depends on pirc_pkg, pirc_calc, pirc_ram and the shared assertion macros
`include "pi_regulator_clamped_delayed_core_defines.svh"

module pi_regulator_clamped_delayed_core #(
   parameter int MAX_DELAY = pirc_pkg::MAX_DELAY_DEFAULT
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_ready,
   input  logic signed [pirc_pkg::REF_W-1:0]       req_reference,
   input  logic signed [pirc_pkg::REF_W-1:0]       req_feedback,
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output logic signed [pirc_pkg::DRIVE_W-1:0]     rsp_drive,
   input  logic                                    csr_valid,
   output logic                                    csr_ready,
   input  logic [pirc_pkg::CSR_INDEX_W-1:0]        csr_index,
   input  logic [pirc_pkg::CSR_DATA_W-1:0]         csr_data
);
   import pirc_pkg::*;

   localparam int PTR_W = (MAX_DELAY > 1) ? $clog2(MAX_DELAY) : 1;
   localparam int EW    = (PTR_W + 1 > DELAY_W) ? PTR_W + 1 : DELAY_W;
   localparam logic [EW-1:0]    MAXD_E   = EW'(MAX_DELAY);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(MAX_DELAY - 1);

   // configuration
   logic [PGAIN_W-1:0]  pgain_ff;
   logic [IGAIN_W-1:0]  igain_ff;
   logic [ILIMIT_W-1:0] ilimit_ff;
   logic [DELAY_W-1:0]  delay_ff;
   gains_type           gains;

   // pipeline control
   logic en;
   logic accept;
   logic wr_en;
   logic bypass;

   // delay addressing
   logic [PTR_W-1:0] wp_ff;
   logic [PTR_W-1:0] wp_in;
   logic [EW-1:0]    d_ext;
   logic [EW-1:0]    d_sel;
   logic [EW-1:0]    wp_ext;
   logic [EW-1:0]    raddr_ext;
   logic [PTR_W-1:0] raddr;
   logic             zero_delay;
   logic [MAX_DELAY-1:0] vld_ff;

   // input register stage
   logic                       s1_valid_ff;
   logic signed [REF_W-1:0]    s1_ref_ff;
   logic signed [REF_W-1:0]    s1_fb_ff;
   logic [PTR_W-1:0]           s1_wp_ff;
   logic                       s1_zero_ff;
   logic                       s1_rd_vld_ff;
   logic                       s1_byp_ff;
   logic signed [DRIVE_W-1:0]  s1_byp_data_ff;

   // datapath
   logic signed [DRIVE_W-1:0] integ_ff;
   logic signed [DRIVE_W-1:0] integ_in;
   logic signed [DRIVE_W-1:0] drive_now;
   logic [DRIVE_W-1:0]        hist_data;
   logic signed [DRIVE_W-1:0] drive_in;

   // result register
   logic                      rsp_valid_ff;
   logic signed [DRIVE_W-1:0] rsp_drive_ff;

   // assertion helpers
   logic signed [32:0] integ_ext;
   logic signed [32:0] lim_ext;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         pgain_ff  <= PGAIN_RESET;
         igain_ff  <= IGAIN_RESET;
         ilimit_ff <= ILIMIT_RESET;
         delay_ff  <= DELAY_RESET;
      end else if (csr_valid) begin
         case (csr_index_type'(csr_index))
            CSR_PGAIN:  pgain_ff  <= csr_data[PGAIN_W-1:0];
            CSR_IGAIN:  igain_ff  <= csr_data[IGAIN_W-1:0];
            CSR_ILIMIT: ilimit_ff <= csr_data[ILIMIT_W-1:0];
            CSR_DELAY:  delay_ff  <= csr_data[DELAY_W-1:0];
            default: ;
         endcase
      end
   end

   assign gains.pgain  = pgain_ff;
   assign gains.igain  = igain_ff;
   assign gains.ilimit = ilimit_ff;

   assign en        = !rsp_valid_ff || rsp_ready;
   assign req_ready = en;
   assign accept    = req_valid && en;
   assign wr_en     = en && s1_valid_ff;

   // read address for the incoming item
   assign d_ext      = EW'(delay_ff);
   assign d_sel      = (d_ext > MAXD_E) ? MAXD_E : d_ext;
   assign wp_ext     = EW'(wp_ff);
   assign raddr_ext  = (wp_ext >= d_sel) ? (wp_ext - d_sel) : (wp_ext + MAXD_E - d_sel);
   assign raddr      = raddr_ext[PTR_W-1:0];
   assign zero_delay = (d_sel == '0);
   assign wp_in      = (wp_ff == PTR_LAST) ? '0 : wp_ff + PTR_W'(1);

   // entry written by the item leaving the input register on this same edge
   assign bypass = wr_en && accept && !zero_delay && (s1_wp_ff == raddr);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         wp_ff       <= '0;
         vld_ff      <= '0;
      end else begin
         if (en) begin
            s1_valid_ff <= req_valid;
         end
         if (accept) begin
            wp_ff <= wp_in;
         end
         if (wr_en) begin
            vld_ff[s1_wp_ff] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ref_ff      <= req_reference;
         s1_fb_ff       <= req_feedback;
         s1_wp_ff       <= wp_ff;
         s1_zero_ff     <= zero_delay;
         s1_rd_vld_ff   <= vld_ff[raddr];
         s1_byp_ff      <= bypass;
         s1_byp_data_ff <= drive_now;
      end
   end

   pirc_calc u_calc (
      .reference  (s1_ref_ff),
      .feedback   (s1_fb_ff),
      .gains      (gains),
      .integ_cur  (integ_ff),
      .integ_next (integ_in),
      .drive_now  (drive_now)
   );

   pirc_ram #(
      .WIDTH (DRIVE_W),
      .DEPTH (MAX_DELAY)
   ) u_hist (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (s1_wp_ff),
      .wr_data (drive_now),
      .rd_en   (accept),
      .rd_addr (raddr),
      .rd_data (hist_data)
   );

   always_comb begin
      if (s1_zero_ff) begin
         drive_in = drive_now;
      end else if (s1_byp_ff) begin
         drive_in = s1_byp_data_ff;
      end else if (s1_rd_vld_ff) begin
         drive_in = $signed(hist_data);
      end else begin
         drive_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         integ_ff     <= '0;
      end else if (en) begin
         rsp_valid_ff <= s1_valid_ff;
         if (s1_valid_ff) begin
            integ_ff <= integ_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         rsp_drive_ff <= drive_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_drive = rsp_drive_ff;

   assign integ_ext = $signed({integ_ff[31], integ_ff});
   assign lim_ext   = $signed({2'b00, ilimit_ff});

   `PIRC_ASSERT_NEXT(a_integ_clamped, clock, reset, wr_en,
      (integ_ext <= lim_ext) && (integ_ext >= -lim_ext), "integrator outside limit")
   `PIRC_ASSERT_SAME(a_bypass_delay_one, clock, reset, bypass,
      d_sel == EW'(1), "history bypass with delay other than one")
   `PIRC_ASSERT_SAME(a_rsp_from_stage, clock, reset, $rose(rsp_valid_ff),
      $past(s1_valid_ff), "result without an item in the input register")
   `PIRC_ASSERT_NEXT(a_pointer_step, clock, reset, accept && !wr_en,
      s1_wp_ff == $past(wp_ff), "input register pointer mismatch")

endmodule

FILE: test/tb_top.sv
// testbench for pi_regulator_clamped_delayed_core: directed and random control samples,
// each drive output checked against a fixed-point regulator predictor kept in the bench
// depends on pirc_pkg and the core rtl
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import pirc_pkg::*;

   localparam int HISTORY_DEPTH   = MAX_DELAY_DEFAULT;
   localparam int HOLD_OFF_CYCLES = 200;
   localparam int WATCHDOG_LIMIT  = 2000;
   localparam int SETTLE_CYCLES   = 6;
   localparam int SAMPLE_TARGET   = 1850;
   localparam longint DRIVE_MAX   = 2147483647;
   localparam longint DRIVE_MIN   = -DRIVE_MAX - 1;

   logic clock = 1'b0;
   logic reset;
   logic req_valid;
   logic req_ready;
   logic signed [REF_W-1:0] req_reference;
   logic signed [REF_W-1:0] req_feedback;
   logic rsp_valid;
   logic rsp_ready;
   logic signed [DRIVE_W-1:0] rsp_drive;
   logic csr_valid;
   logic csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0] csr_data;

   // predictor state
   logic [PGAIN_W-1:0] pgain_q;
   logic [IGAIN_W-1:0] igain_q;
   logic [ILIMIT_W-1:0] ilimit_q;
   logic [DELAY_W-1:0] delay_q;
   logic signed [DRIVE_W-1:0] integ_q;
   logic signed [DRIVE_W-1:0] history_q [HISTORY_DEPTH];
   int unsigned hist_ptr_q;
   logic signed [DRIVE_W-1:0] drive_expected [$];

   int unsigned failures = 0;
   int unsigned samples_sent = 0;
   int unsigned stuck_cycles = 0;
   bit src_gaps_on = 1'b0;
   bit sink_stalls_on = 1'b0;
   bit hold_off_req = 1'b0;

   pi_regulator_clamped_delayed_core i_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_reference (req_reference),
      .req_feedback  (req_feedback),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_drive     (rsp_drive),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data)
   );

   always #5 clock = ~clock;

   function automatic logic signed [DRIVE_W-1:0] regulate_sample(
         input logic signed [REF_W-1:0] target,
         input logic signed [REF_W-1:0] measured);
      longint err;
      longint lim;
      longint acc;
      longint outv;
      int unsigned lag;
      logic signed [DRIVE_W-1:0] now;
      logic signed [DRIVE_W-1:0] delayed;
      err = longint'(target) - longint'(measured);
      lim = longint'(ilimit_q);
      // round half up to q16.16, arithmetic shift is a floor
      acc = longint'(integ_q) + ((longint'(igain_q) * err + 8192) >>> 14);
      if (acc > lim) begin
         acc = lim;
      end else if (acc < -lim) begin
         acc = -lim;
      end
      integ_q = acc[DRIVE_W-1:0];
      outv = acc + ((longint'(pgain_q) * err + 2) >>> 2);
      if (outv > DRIVE_MAX) begin
         outv = DRIVE_MAX;
      end else if (outv < DRIVE_MIN) begin
         outv = DRIVE_MIN;
      end
      now = outv[DRIVE_W-1:0];
      lag = (delay_q > HISTORY_DEPTH) ? HISTORY_DEPTH : delay_q;
      if (lag == 0) begin
         delayed = now;
      end else begin
         delayed = history_q[(hist_ptr_q + HISTORY_DEPTH - lag) % HISTORY_DEPTH];
      end
      history_q[hist_ptr_q] = now;
      hist_ptr_q = (hist_ptr_q + 1) % HISTORY_DEPTH;
      return delayed;
   endfunction

   function automatic int unsigned pick_gap();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 88) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [CSR_DATA_W-1:0] pick_setting(input int unsigned width);
      logic [CSR_DATA_W-1:0] mask;
      int unsigned roll;
      mask = {CSR_DATA_W{1'b1}} >> (CSR_DATA_W - width);
      roll = $urandom_range(0, 9);
      if (roll == 0) return '0;
      if (roll == 1) return mask;
      if (roll < 5) return $urandom & mask;
      return $urandom_range(0, 1 << (width - 6));
   endfunction

   // predictor, config tracking and drive checking
   always @(posedge clock) begin
      logic signed [DRIVE_W-1:0] want;
      if (reset) begin
         pgain_q = PGAIN_RESET;
         igain_q = IGAIN_RESET;
         ilimit_q = ILIMIT_RESET;
         delay_q = DELAY_RESET;
         integ_q = '0;
         foreach (history_q[i]) history_q[i] = '0;
         hist_ptr_q = 0;
         drive_expected.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index_type'(csr_index))
               CSR_PGAIN:  pgain_q = csr_data[PGAIN_W-1:0];
               CSR_IGAIN:  igain_q = csr_data[IGAIN_W-1:0];
               CSR_ILIMIT: ilimit_q = csr_data[ILIMIT_W-1:0];
               CSR_DELAY:  delay_q = csr_data[DELAY_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            drive_expected.push_back(regulate_sample(req_reference, req_feedback));
         end
         if (rsp_valid && rsp_ready) begin
            if (drive_expected.size() == 0) begin
               if (failures < 10) $display("unexpected drive %0d at %0t", rsp_drive, $time);
               failures++;
            end else begin
               want = drive_expected.pop_front();
               if (rsp_drive !== want) begin
                  if (failures < 10) begin
                     $display("drive mismatch at %0t: expected %0d, actual %0d",
                              $time, want, rsp_drive);
                  end
                  failures++;
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         stuck_cycles <= 0;
      end else if (stuck_cycles >= WATCHDOG_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
      end
   end

   initial begin : sink_pacing
      int unsigned stall;
      rsp_ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_req) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
            hold_off_req = 1'b0;
            rsp_ready <= 1'b1;
         end else if (sink_stalls_on && $urandom_range(0, 3) == 0) begin
            stall = 1 + pick_gap();
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   task automatic send_sample(input logic signed [REF_W-1:0] target,
                              input logic signed [REF_W-1:0] measured);
      int unsigned gap;
      csr_valid <= 1'b0;
      req_valid <= 1'b1;
      req_reference <= target;
      req_feedback <= measured;
      do @(posedge clock); while (!req_ready);
      samples_sent++;
      gap = src_gaps_on ? pick_gap() : 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [CSR_DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      csr_valid <= 1'b0;
      @(posedge clock);
      while (drive_expected.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // reset gains, history reads back zeros for the first three items
   task automatic test_reset_defaults();
      send_sample(16'sh7FFF, -16'sh8000);
      send_sample(-16'sh8000, 16'sh7FFF);
      send_sample(16'sd0, 16'sd0);
      send_sample(16'sd1024, 16'sd0);
      send_sample(-16'sd1, 16'sd0);
      send_sample(16'sd0, 16'sd1);
      drain();
   endtask

   task automatic test_delay_extremes();
      write_reg(CSR_DELAY, 32'd0);
      send_sample(16'sd500, -16'sd200);
      send_sample(-16'sd700, 16'sd300);
      drain();
      write_reg(CSR_DELAY, 32'd8);
      send_sample(16'sd1200, 16'sd0);
      send_sample(-16'sd50, 16'sd40);
      drain();
      write_reg(CSR_DELAY, 32'd15);
      send_sample(16'sd3000, -16'sd3000);
      send_sample(16'sd10, 16'sd20);
      drain();
   endtask

   // halves round upward for both products
   task automatic test_rounding();
      write_reg(CSR_PGAIN, 32'd2);
      write_reg(CSR_IGAIN, 32'd8192);
      write_reg(CSR_ILIMIT, 32'h7FFF_FFFF);
      write_reg(CSR_DELAY, 32'd0);
      send_sample(16'sd1, 16'sd0);
      send_sample(16'sd0, 16'sd1);
      drain();
   endtask

   task automatic test_saturation();
      write_reg(CSR_PGAIN, 32'hFFFF);
      write_reg(CSR_IGAIN, 32'hFF_FFFF);
      write_reg(CSR_ILIMIT, 32'h7FFF_FFFF);
      send_sample(16'sh7FFF, -16'sh8000);
      send_sample(16'sh7FFF, -16'sh8000);
      send_sample(-16'sh8000, 16'sh7FFF);
      send_sample(-16'sh8000, 16'sh7FFF);
      drain();
   endtask

   // integrator above a newly lowered limit is pulled in on the next item
   task automatic test_limit_lowered();
      send_sample(16'sh7FFF, 16'sd0);
      send_sample(16'sh7FFF, 16'sd0);
      drain();
      write_reg(CSR_ILIMIT, 32'd1000);
      send_sample(16'sd0, 16'sd0);
      drain();
      write_reg(CSR_ILIMIT, 32'd0);
      send_sample(16'sd100, 16'sd0);
      drain();
   endtask

   task automatic test_backpressure();
      write_reg(CSR_DELAY, 32'd8);
      src_gaps_on = 1'b0;
      sink_stalls_on = 1'b0;
      hold_off_req = 1'b1;
      for (int i = 0; i < 40; i++) begin
         send_sample(REF_W'($urandom), REF_W'($urandom));
      end
      drain();
   endtask

   task automatic test_random_phases();
      int unsigned burst;
      int unsigned roll;
      int level;
      bit windup;
      logic signed [REF_W-1:0] target;
      logic signed [REF_W-1:0] measured;
      while (samples_sent < SAMPLE_TARGET) begin
         windup = ($urandom_range(0, 6) == 0);
         if (windup) begin
            write_reg(CSR_PGAIN, $urandom_range(0, 1) ? 32'hFFFF : $urandom_range(0, 65535));
            write_reg(CSR_IGAIN, 32'hFF_FFFF);
            write_reg(CSR_ILIMIT, $urandom_range(0, 1) ? 32'h7FFF_FFFF : pick_setting(ILIMIT_W));
         end else begin
            if ($urandom_range(0, 9) < 6) write_reg(CSR_PGAIN, pick_setting(PGAIN_W));
            if ($urandom_range(0, 9) < 6) write_reg(CSR_IGAIN, pick_setting(IGAIN_W));
            if ($urandom_range(0, 9) < 6) write_reg(CSR_ILIMIT, pick_setting(ILIMIT_W));
         end
         write_reg(CSR_DELAY, $urandom_range(0, 15));
         src_gaps_on = ($urandom_range(0, 3) != 0);
         sink_stalls_on = ($urandom_range(0, 3) != 0);
         burst = windup ? 100 : $urandom_range(10, 80);
         target = REF_W'($urandom);
         for (int i = 0; i < burst; i++) begin
            if (windup) begin
               // drive the integrator into its clamp, then all the way back
               if (i < burst / 2) begin
                  target = 16'sh7FFF;
                  measured = REF_W'(-16'sh8000 + $urandom_range(0, 255));
               end else begin
                  target = -16'sh8000;
                  measured = REF_W'(16'sh7FFF - $urandom_range(0, 255));
               end
            end else begin
               if ($urandom_range(0, 9) == 0) target = REF_W'($urandom);
               roll = $urandom_range(0, 9);
               if (roll == 0) begin
                  target = REF_W'($urandom);
                  measured = REF_W'($urandom);
               end else if (roll == 1) begin
                  measured = $urandom_range(0, 1) ? 16'sh7FFF : -16'sh8000;
               end else begin
                  level = int'(target) + int'($urandom_range(0, 512)) - 256;
                  if (level > 32767) level = 32767;
                  if (level < -32768) level = -32768;
                  measured = level[REF_W-1:0];
               end
            end
            send_sample(target, measured);
         end
         drain();
      end
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_reference = '0;
      req_feedback = '0;
      csr_valid = 1'b0;
      csr_index = CSR_PGAIN;
      csr_data = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_defaults();
      test_delay_extremes();
      test_rounding();
      test_saturation();
      test_limit_lowered();
      test_backpressure();
      test_random_phases();
      drain();
      if (failures == 0 && drive_expected.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
